@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dpalu_pkg.sv @@
// ---------------------------------------------------------------------------
// dpalu_pkg
// Types and constants of the data-processing execute stage.
// ---------------------------------------------------------------------------
package dpalu_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned CFG_IDX_W = 1;

  // status word flag positions
  localparam int unsigned FLAG_N = 31;
  localparam int unsigned FLAG_Z = 30;
  localparam int unsigned FLAG_C = 29;
  localparam int unsigned FLAG_V = 28;

  // instruction fields
  localparam int unsigned S_BIT = 20;
  localparam logic [REG_IDX_W-1:0] PC_IDX = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAVED_STATUS  = 1'b0,
    CFG_SAVED_PRESENT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_AND = 4'd0, OP_EOR = 4'd1, OP_SUB = 4'd2, OP_RSB = 4'd3,
    OP_ADD = 4'd4, OP_ADC = 4'd5, OP_SBC = 4'd6, OP_RSC = 4'd7,
    OP_TST = 4'd8, OP_TEQ = 4'd9, OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } opcode_e;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0, CC_NE = 4'd1, CC_CS = 4'd2, CC_CC = 4'd3,
    CC_MI = 4'd4, CC_PL = 4'd5, CC_VS = 4'd6, CC_VC = 4'd7,
    CC_HI = 4'd8, CC_LS = 4'd9, CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_e;

  // outcome of one instruction, execute unit to top level
  typedef struct packed {
    logic            executed;
    logic            dest_written;
    logic [XLEN-1:0] dest_value;
    logic [XLEN-1:0] status_after;
  } exec_res_t;

endpackage

@@ hw/rtl/dpalu_in_if.sv @@
// ---------------------------------------------------------------------------
// dpalu_in_if
// Instruction channel: valid/ready with instruction and shifter operand.
// ---------------------------------------------------------------------------
interface dpalu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [31:0] shifter_value;
  logic        shifter_carry;

  modport source (output valid, output instruction, output shifter_value,
                  output shifter_carry, input ready);
  modport sink   (input valid, input instruction, input shifter_value,
                  input shifter_carry, output ready);
endinterface

@@ hw/rtl/dpalu_out_if.sv @@
// ---------------------------------------------------------------------------
// dpalu_out_if
// Result channel: valid/ready with the outcome of one instruction.
// ---------------------------------------------------------------------------
interface dpalu_out_if;
  logic        valid;
  logic        ready;
  logic        executed;
  logic        dest_written;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic [31:0] status_after;

  modport source (output valid, output executed, output dest_written,
                  output dest_index, output dest_value, output status_after,
                  input ready);
  modport sink   (input valid, input executed, input dest_written,
                  input dest_index, input dest_value, input status_after,
                  output ready);
endinterface

@@ hw/rtl/dpalu_ram.sv @@
// ---------------------------------------------------------------------------
// dpalu_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dpalu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/dpalu_exec.sv @@
// ---------------------------------------------------------------------------
// dpalu_exec
// Condition check, ALU and flag update for one instruction.
// ---------------------------------------------------------------------------
module dpalu_exec (
  input  logic [31:0]           instr_i,
  input  logic [31:0]           op2_i,
  input  logic                  shc_i,
  input  logic [31:0]           rn_val_i,
  input  logic [31:0]           status_i,
  input  logic [31:0]           saved_status_i,
  input  logic                  saved_present_i,
  output dpalu_pkg::exec_res_t  res_o
);
  import dpalu_pkg::*;

  cond_e          cond;
  opcode_e        opc;
  logic [3:0]     rd;
  logic           sflag;
  logic           n, z, c, v;
  logic           pass;
  logic [31:0]    add_x, add_y;
  logic           add_cin;
  logic [32:0]    sum;
  logic           add_v;
  logic [31:0]    alu;
  logic           arith;
  logic           is_cmp;
  logic [31:0]    st;

  assign cond  = cond_e'(instr_i[31:28]);
  assign opc   = opcode_e'(instr_i[24:21]);
  assign rd    = instr_i[15:12];
  assign sflag = instr_i[S_BIT];
  assign n     = status_i[FLAG_N];
  assign z     = status_i[FLAG_Z];
  assign c     = status_i[FLAG_C];
  assign v     = status_i[FLAG_V];

  always_comb begin
    case (cond)
      CC_EQ:   pass = z;
      CC_NE:   pass = !z;
      CC_CS:   pass = c;
      CC_CC:   pass = !c;
      CC_MI:   pass = n;
      CC_PL:   pass = !n;
      CC_VS:   pass = v;
      CC_VC:   pass = !v;
      CC_HI:   pass = c && !z;
      CC_LS:   pass = !c || z;
      CC_GE:   pass = (n == v);
      CC_LT:   pass = (n != v);
      CC_GT:   pass = !z && (n == v);
      CC_LE:   pass = z || (n != v);
      CC_AL:   pass = 1'b1;
      default: pass = 1'b0;
    endcase
  end

  // operand steering for the single adder; subtraction adds the inverse
  always_comb begin
    add_x   = rn_val_i;
    add_y   = op2_i;
    add_cin = 1'b0;
    case (opc)
      OP_SUB, OP_CMP: begin
        add_y   = ~op2_i;
        add_cin = 1'b1;
      end
      OP_RSB: begin
        add_x   = op2_i;
        add_y   = ~rn_val_i;
        add_cin = 1'b1;
      end
      OP_ADC: add_cin = c;
      OP_SBC: begin
        add_y   = ~op2_i;
        add_cin = c;
      end
      OP_RSC: begin
        add_x   = op2_i;
        add_y   = ~rn_val_i;
        add_cin = c;
      end
      default: add_cin = 1'b0;
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
  assign add_v = (add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]);

  always_comb begin
    arith = 1'b0;
    case (opc)
      OP_AND, OP_TST: alu = rn_val_i & op2_i;
      OP_EOR, OP_TEQ: alu = rn_val_i ^ op2_i;
      OP_ORR:         alu = rn_val_i | op2_i;
      OP_MOV:         alu = op2_i;
      OP_BIC:         alu = rn_val_i & ~op2_i;
      OP_MVN:         alu = ~op2_i;
      default: begin
        alu   = sum[31:0];
        arith = 1'b1;
      end
    endcase
  end

  assign is_cmp = (opc == OP_TST) || (opc == OP_TEQ) || (opc == OP_CMP) || (opc == OP_CMN);

  always_comb begin
    st = status_i;
    if (!is_cmp && sflag && (rd == PC_IDX)) begin
      if (saved_present_i) begin
        st = saved_status_i;
      end
    end else if (is_cmp || sflag) begin
      st[FLAG_N] = alu[31];
      st[FLAG_Z] = (alu == 32'd0);
      st[FLAG_C] = arith ? sum[32] : shc_i;
      if (arith) begin
        st[FLAG_V] = add_v;
      end
    end
  end

  always_comb begin
    res_o.executed     = pass;
    res_o.dest_written = pass && !is_cmp;
    res_o.dest_value   = pass ? alu : 32'd0;
    res_o.status_after = pass ? st : status_i;
  end
endmodule

@@ hw/rtl/arm_data_processing_alu.sv @@
// ---------------------------------------------------------------------------
// arm_data_processing_alu
// Execute stage for ARM data-processing instructions with a RAM register file.
// ---------------------------------------------------------------------------
// Usage:
//   req_i carries one instruction per transaction together with the operand
//   and carry out of the external shifter. rsp_o returns one transaction per
//   instruction, in order: executed flag, destination write flag and index,
//   ALU result and the status word after the instruction.
//   The saved status word and its present flag are written through cfg_*_i;
//   the user must do so only while the block is idle, which it does not enforce.
// Pipeline and throughput:
//   The register file read of Rn is issued in the accept cycle (RAM with
//   registered read data), execute and write-back follow in the execute stage,
//   the result sits in the output register. One instruction per cycle is
//   sustained while rsp_o is not held; a write to Rn by the preceding
//   instruction is forwarded around the RAM, flags live in flops.
// Reset:
//   Registers read as zero (per-entry valid bits), status and config clear.
// Stalls:
//   While rsp_o is held, one instruction waits in the execute stage with its
//   read data frozen, and req_i.ready drops only when both are occupied.
// ---------------------------------------------------------------------------
module arm_data_processing_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dpalu_in_if.sink                           req_i,
  dpalu_out_if.source                        rsp_o,
  input  logic                               cfg_we_i,
  input  logic [dpalu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpalu_pkg::XLEN-1:0]         cfg_data_i
);
  import dpalu_pkg::*;

  `include "assert_macros.svh"

  // configuration
  logic [XLEN-1:0]      saved_status_q;
  logic                 saved_present_q;

  // architectural flags
  logic [XLEN-1:0]      status_q;

  // execute stage
  logic                 s1_valid_q;
  logic [XLEN-1:0]      s1_instr_q;
  logic [XLEN-1:0]      s1_op2_q;
  logic                 s1_shc_q;
  logic                 s1_adv;
  logic [REG_IDX_W-1:0] s1_rn;
  logic [REG_IDX_W-1:0] s1_rd;

  // forwarding of the write that lands on the same edge as the read
  logic                 fwd_hit_q;
  logic [XLEN-1:0]      fwd_data_q;

  // register file
  logic [NUM_REGS-1:0]  reg_vld_q;
  logic [XLEN-1:0]      ram_rdata;
  logic                 ram_we;
  logic [XLEN-1:0]      rn_val;

  // output register
  logic                 out_valid_q;
  logic                 out_exec_q;
  logic                 out_wr_q;
  logic [REG_IDX_W-1:0] out_idx_q;
  logic [XLEN-1:0]      out_val_q;
  logic [XLEN-1:0]      out_st_q;

  logic                 accept;
  exec_res_t            res;

  // ---- handshake --------------------------------------------------------
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  assign s1_rn  = s1_instr_q[19:16];
  assign s1_rd  = s1_instr_q[15:12];
  assign ram_we = s1_adv && res.dest_written;

  // ---- register file ----------------------------------------------------
  dpalu_ram #(
    .Width (XLEN),
    .Depth (NUM_REGS)
  ) u_regfile (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_rd),
    .wdata_i (res.dest_value),
    .re_i    (accept),
    .raddr_i (req_i.instruction[19:16]),
    .rdata_o (ram_rdata)
  );

  // prefer the forwarded write; unwritten entries read as zero
  always_comb begin
    if (fwd_hit_q) begin
      rn_val = fwd_data_q;
    end else if (reg_vld_q[s1_rn]) begin
      rn_val = ram_rdata;
    end else begin
      rn_val = '0;
    end
  end

  dpalu_exec u_exec (
    .instr_i         (s1_instr_q),
    .op2_i           (s1_op2_q),
    .shc_i           (s1_shc_q),
    .rn_val_i        (rn_val),
    .status_i        (status_q),
    .saved_status_i  (saved_status_q),
    .saved_present_i (saved_present_q),
    .res_o           (res)
  );

  // ---- control state ----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_status_q  <= '0;
      saved_present_q <= 1'b0;
      status_q        <= '0;
      s1_valid_q      <= 1'b0;
      fwd_hit_q       <= 1'b0;
      reg_vld_q       <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SAVED_STATUS:  saved_status_q  <= cfg_data_i;
          CFG_SAVED_PRESENT: saved_present_q <= cfg_data_i[0];
          default:           saved_present_q <= saved_present_q;
        endcase
      end
      if (s1_adv) begin
        status_q <= res.status_after;
      end
      if (ram_we) begin
        reg_vld_q[s1_rd] <= 1'b1;
      end
      // advance or drop the execute slot
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= ram_we && (s1_rd == req_i.instruction[19:16]);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload ----------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_instr_q <= req_i.instruction;
      s1_op2_q   <= req_i.shifter_value;
      s1_shc_q   <= req_i.shifter_carry;
      fwd_data_q <= res.dest_value;
    end
    if (s1_adv) begin
      out_exec_q <= res.executed;
      out_wr_q   <= res.dest_written;
      out_idx_q  <= s1_rd;
      out_val_q  <= res.dest_value;
      out_st_q   <= res.status_after;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.executed     = out_exec_q;
  assign rsp_o.dest_written = out_wr_q;
  assign rsp_o.dest_index   = out_idx_q;
  assign rsp_o.dest_value   = out_val_q;
  assign rsp_o.status_after = out_st_q;

  // ---- assertions -------------------------------------------------------
  `ASSERT_IMPL(a_wr_needs_exec, clk_i, rst_ni, out_valid_q && out_wr_q, out_exec_q,
    "destination written by an instruction that did not execute")
  `ASSERT_IMPL(a_skip_zero, clk_i, rst_ni, out_valid_q && !out_exec_q, out_val_q == '0,
    "skipped instruction reports a non-zero result")
  `ASSERT_NEXT(a_skip_keeps_flags, clk_i, rst_ni, s1_adv && !res.executed,
    status_q == $past(status_q), "skipped instruction changed the status word")
  `ASSERT_NEXT(a_wr_lands_out, clk_i, rst_ni, ram_we, out_valid_q && out_wr_q,
    "register write without a matching response")
endmodule

@@ test/tb_arm_data_processing_alu.sv @@
// ---------------------------------------------------------------------------
// tb_arm_data_processing_alu
// Self-checking bench for the ARM data-processing execute stage. A scoreboard
// class keeps its own register file, status word and saved status, works out
// the outcome of every accepted instruction and compares it field by field
// with the response stream. Directed corner cases come first, then random
// instruction streams under several saved-status settings and idle patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arm_data_processing_alu;
  import dpalu_pkg::*;

  typedef struct packed {
    logic            executed;
    logic            dest_written;
    logic [3:0]      dest_index;
    logic [XLEN-1:0] dest_value;
    logic [XLEN-1:0] status_after;
  } dp_outcome_t;

  class dp_exec_scoreboard;
    logic [XLEN-1:0] regs [NUM_REGS];
    logic [XLEN-1:0] cpsr;
    logic [XLEN-1:0] saved_psr;
    logic            saved_valid;
    dp_outcome_t     outcome_q [$];
    int unsigned     mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      cpsr        = '0;
      saved_psr   = '0;
      saved_valid = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_config(cfg_idx_e idx, logic [XLEN-1:0] data);
      case (idx)
        CFG_SAVED_STATUS:  saved_psr   = data;
        CFG_SAVED_PRESENT: saved_valid = data[0];
        default: ;
      endcase
    endfunction

    function bit cond_holds(cond_e cc);
      logic n, z, c, v;
      n = cpsr[FLAG_N];
      z = cpsr[FLAG_Z];
      c = cpsr[FLAG_C];
      v = cpsr[FLAG_V];
      case (cc)
        CC_EQ: return z;
        CC_NE: return !z;
        CC_CS: return c;
        CC_CC: return !c;
        CC_MI: return n;
        CC_PL: return !n;
        CC_VS: return v;
        CC_VC: return !v;
        CC_HI: return c && !z;
        CC_LS: return !c || z;
        CC_GE: return n == v;
        CC_LT: return n != v;
        CC_GT: return !z && (n == v);
        CC_LE: return z || (n != v);
        CC_AL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void note_instruction(logic [31:0] ins, logic [XLEN-1:0] op2, logic shc);
      opcode_e         op;
      logic            s;
      logic [3:0]      rn, rd;
      logic [XLEN-1:0] a, x, y, res;
      logic [XLEN:0]   sum;
      logic            cy, cout, ovf;
      bit              arith, cmp;
      dp_outcome_t     want;
      op    = opcode_e'(ins[24:21]);
      s     = ins[S_BIT];
      rn    = ins[19:16];
      rd    = ins[15:12];
      a     = regs[rn];
      want  = '{executed: 1'b0, dest_written: 1'b0, dest_index: rd,
                dest_value: '0, status_after: cpsr};
      if (cond_holds(cond_e'(ins[31:28]))) begin
        arith = 1'b0;
        cout  = shc;
        ovf   = 1'b0;
        x     = '0;
        y     = '0;
        cy    = 1'b0;
        res   = '0;
        case (op)
          OP_AND, OP_TST: res = a & op2;
          OP_EOR, OP_TEQ: res = a ^ op2;
          OP_SUB, OP_CMP: begin x = a;   y = ~op2; cy = 1'b1;         arith = 1'b1; end
          OP_RSB:         begin x = op2; y = ~a;   cy = 1'b1;         arith = 1'b1; end
          OP_ADD, OP_CMN: begin x = a;   y = op2;  cy = 1'b0;         arith = 1'b1; end
          OP_ADC:         begin x = a;   y = op2;  cy = cpsr[FLAG_C]; arith = 1'b1; end
          OP_SBC:         begin x = a;   y = ~op2; cy = cpsr[FLAG_C]; arith = 1'b1; end
          OP_RSC:         begin x = op2; y = ~a;   cy = cpsr[FLAG_C]; arith = 1'b1; end
          OP_ORR:         res = a | op2;
          OP_MOV:         res = op2;
          OP_BIC:         res = a & ~op2;
          default:        res = ~op2;
        endcase
        if (arith) begin
          sum  = {1'b0, x} + {1'b0, y} + {{XLEN{1'b0}}, cy};
          res  = sum[XLEN-1:0];
          cout = sum[XLEN];
          ovf  = (x[XLEN-1] == y[XLEN-1]) && (res[XLEN-1] != x[XLEN-1]);
        end
        cmp = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
        if (!cmp) regs[rd] = res;
        if (!cmp && s && rd == PC_IDX) begin
          if (saved_valid) cpsr = saved_psr;
        end else if (cmp || s) begin
          cpsr[FLAG_N] = res[XLEN-1];
          cpsr[FLAG_Z] = (res == '0);
          cpsr[FLAG_C] = cout;
          if (arith) cpsr[FLAG_V] = ovf;
        end
        want.executed     = 1'b1;
        want.dest_written = !cmp;
        want.dest_value   = res;
        want.status_after = cpsr;
      end
      outcome_q.push_back(want);
    endfunction

    function void compare_field(string field, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(dp_outcome_t got);
      dp_outcome_t want;
      if (outcome_q.size() == 0) begin
        $display("%0t: response with no instruction outstanding, expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      compare_field("executed", XLEN'(want.executed), XLEN'(got.executed));
      compare_field("dest_written", XLEN'(want.dest_written), XLEN'(got.dest_written));
      compare_field("dest_index", XLEN'(want.dest_index), XLEN'(got.dest_index));
      compare_field("dest_value", want.dest_value, got.dest_value);
      compare_field("status_after", want.status_after, got.status_after);
    endfunction

    function int unsigned outstanding();
      return outcome_q.size();
    endfunction
  endclass

  // quiet cycles tolerated before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 3000;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;
  logic [XLEN-1:0] cfg_data;

  dpalu_in_if  req_if ();
  dpalu_out_if rsp_if ();

  dp_exec_scoreboard sb = new();

  // idle chances in percent, and a numbered request for a long receiver hold
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_len = 0;
  int unsigned sink_hold_seq = 0;
  int unsigned quiet_cycles  = 0;
  logic [3:0]  last_rd       = 4'd0;

  arm_data_processing_alu uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: check every transaction seen at the edge, then pick the
  // next ready value. A new hold request takes over the ready line for its
  // whole length, counted here, so the block backs up into its input.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_taken;
    dp_outcome_t seen;
    hold_left    = 0;
    hold_taken   = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        seen.executed     = rsp_if.executed;
        seen.dest_written = rsp_if.dest_written;
        seen.dest_index   = rsp_if.dest_index;
        seen.dest_value   = rsp_if.dest_value;
        seen.status_after = rsp_if.status_after;
        sb.check_result(seen);
      end
      if (sink_hold_seq != hold_taken) begin
        hold_left  = sink_hold_len;
        hold_taken = sink_hold_seq;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Assemble a data-processing word; the operand2 bits are left clear since
  // the shifter result arrives separately.
  function automatic logic [31:0] dp_word(cond_e cc, opcode_e op, logic s,
                                          logic [3:0] rn, logic [3:0] rd);
    return {cc, 3'b000, op, s, rn, rd, 12'h000};
  endfunction

  // Random word: mostly unconditional so the register state keeps moving,
  // often reading the register just written to stress forwarding, and with
  // R15 as destination more often than chance to hit the saved-status copy.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(9) < 7) w[31:28] = CC_AL;
    if ($urandom_range(9) < 3) w[19:16] = last_rd;
    if ($urandom_range(9) == 0) w[15:12] = PC_IDX;
    return w;
  endfunction

  function automatic logic [XLEN-1:0] random_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return XLEN'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Offer one instruction, with random idle cycles in front, and hold it
  // until the block takes it. The scoreboard learns of it at the accepting edge.
  task automatic issue_instruction(input logic [31:0] ins, input logic [XLEN-1:0] op2,
                                   input logic shc);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.instruction   <= ins;
    req_if.shifter_value <= op2;
    req_if.shifter_carry <= shc;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    sb.note_instruction(ins, op2, shc);
    last_rd = ins[15:12];
  endtask

  // Random stream; the long receiver hold fires part-way through if asked.
  task automatic issue_random(input int unsigned count, input int unsigned hold_at,
                              input int unsigned hold_len);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == hold_at && hold_len != 0) begin
        sink_hold_len = hold_len;
        sink_hold_seq++;
      end
      issue_instruction(random_instruction(), random_operand(), 1'($urandom_range(1)));
    end
    req_if.valid <= 1'b0;
  endtask

  // Wait until every response is back, then leave slack before going on.
  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; drop the enable once afterwards.
  task automatic set_saved_status(input logic [XLEN-1:0] word, input logic present);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SAVED_STATUS;
    cfg_data <= word;
    @(posedge clk);
    sb.write_config(CFG_SAVED_STATUS, word);
    cfg_idx  <= CFG_SAVED_PRESENT;
    cfg_data <= XLEN'(present);
    @(posedge clk);
    sb.write_config(CFG_SAVED_PRESENT, XLEN'(present));
    cfg_we   <= 1'b0;
  endtask

  initial begin
    // Hold every input at a known value while reset is held low.
    rst_n                <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.instruction   <= '0;
    req_if.shifter_value <= '0;
    req_if.shifter_carry <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_SAVED_STATUS;
    cfg_data             <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct  = 32;
    sink_idle_pct = 56;

    // Directed corners, run with the reset configuration (no saved status).
    issue_instruction(dp_word(CC_AL, OP_MOV, 1'b1, 4'd0, 4'd1), 32'hFFFF_FFFF, 1'b1);
    issue_instruction(dp_word(CC_AL, OP_MOV, 1'b1, 4'd0, 4'd2), 32'h8000_0000, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_MOV, 1'b0, 4'd0, 4'd3), 32'h7FFF_FFFF, 1'b1);
    // signed overflow on add, then carry-in clear and set on ADC
    issue_instruction(dp_word(CC_AL, OP_ADD, 1'b1, 4'd3, 4'd4), 32'h0000_0001, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_ADC, 1'b1, 4'd1, 4'd5), 32'h0000_0001, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_ADC, 1'b1, 4'd1, 4'd5), 32'h0000_0000, 1'b0);
    // subtract family: overflow on SUB, borrow chain through SBC and RSC
    issue_instruction(dp_word(CC_AL, OP_SUB, 1'b1, 4'd2, 4'd6), 32'h0000_0001, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_RSB, 1'b1, 4'd1, 4'd7), 32'h0000_0000, 1'b1);
    issue_instruction(dp_word(CC_AL, OP_SBC, 1'b1, 4'd0, 4'd8), 32'h0000_0000, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_RSC, 1'b1, 4'd3, 4'd9), 32'hFFFF_FFFF, 1'b1);
    // logical ops take C from the shifter and leave V alone
    issue_instruction(dp_word(CC_AL, OP_AND, 1'b1, 4'd1, 4'd10), 32'h0000_0000, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_EOR, 1'b1, 4'd1, 4'd11), 32'hFFFF_FFFF, 1'b1);
    issue_instruction(dp_word(CC_AL, OP_ORR, 1'b1, 4'd2, 4'd12), 32'h7FFF_FFFF, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_BIC, 1'b1, 4'd1, 4'd13), 32'h0F0F_0F0F, 1'b1);
    issue_instruction(dp_word(CC_AL, OP_MVN, 1'b1, 4'd0, 4'd14), 32'h0000_0000, 1'b0);
    // compares set flags with S clear and Rd 15, and never write Rd
    issue_instruction(dp_word(CC_AL, OP_TST, 1'b0, 4'd1, 4'd15), 32'h8000_0000, 1'b1);
    issue_instruction(dp_word(CC_AL, OP_TEQ, 1'b0, 4'd1, 4'd0), 32'hFFFF_FFFF, 1'b0);
    issue_instruction(dp_word(CC_EQ, OP_CMP, 1'b1, 4'd2, 4'd15), 32'h8000_0000, 1'b0);
    issue_instruction(dp_word(CC_NE, OP_MOV, 1'b1, 4'd0, 4'd6), 32'h1234_5678, 1'b1);
    issue_instruction(dp_word(CC_AL, OP_CMN, 1'b1, 4'd1, 4'd0), 32'h0000_0001, 1'b0);
    // never condition: nothing changes
    issue_instruction(dp_word(CC_NV, OP_MOV, 1'b1, 4'd0, 4'd1), 32'h0000_0000, 1'b0);
    // R15 reads back its stored value, no pipeline offset
    issue_instruction(dp_word(CC_AL, OP_MOV, 1'b0, 4'd0, 4'd15), 32'hDEAD_BEEF, 1'b0);
    issue_instruction(dp_word(CC_AL, OP_ADD, 1'b0, 4'd15, 4'd2), 32'h0000_0001, 1'b0);
    // S with Rd 15 and no saved status: status must hold
    issue_instruction(dp_word(CC_AL, OP_MOV, 1'b1, 4'd0, 4'd15), 32'h0000_0000, 1'b1);
    issue_instruction(dp_word(CC_HI, OP_SUB, 1'b1, 4'd15, 4'd3), 32'hFFFF_FFFF, 1'b0);
    req_if.valid <= 1'b0;
    drain();

    // Random content in the saved status, copy enabled; one long receiver
    // hold part-way through so the input stalls.
    set_saved_status($urandom, 1'b1);
    issue_random(510, 170, 150);
    drain();

    // All-ones saved status, idle pattern swapped.
    src_idle_pct  = 56;
    sink_idle_pct = 32;
    set_saved_status('1, 1'b1);
    issue_random(510, 0, 0);
    drain();

    // No idling at all: zero saved status with the copy disabled, then a
    // random word with it enabled again.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_saved_status('0, 1'b0);
    issue_random(250, 0, 0);
    drain();
    set_saved_status($urandom, 1'b1);
    issue_random(260, 0, 0);

    // Let anything stray surface before the verdict.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
